/* hdl/txtovl_pkg.sv */
// Shared constants, register indexes and the 5x7 font for the text band overlay.
package txtovl_pkg;

  localparam int LINE_WIDTH = 320;
  localparam int BAND_ROWS  = 24;
  localparam int MAX_CHARS  = 64;

  localparam int GLYPH_ROWS     = 7;
  localparam int GLYPH_COLS     = 5;
  localparam int TEXT_START_COL = 3;
  localparam int CELL_COLS      = 6;

  localparam int COL_W   = $clog2(LINE_WIDTH);
  localparam int ROW_W   = $clog2(BAND_ROWS + 8);
  localparam int ADDR_W  = $clog2(MAX_CHARS);
  localparam int COUNT_W = $clog2(MAX_CHARS + 1);

  // Reciprocals of the cell width (6, 12, 18) scaled by 2^RECIP_SHIFT.
  // They give an exact quotient for every column below the line width.
  localparam int RECIP_SHIFT = 12;
  localparam logic [9:0] RECIP_S1 = 10'd683;
  localparam logic [9:0] RECIP_S2 = 10'd342;
  localparam logic [9:0] RECIP_S3 = 10'd228;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SCALE      = 1'b0,
    REG_TEXT_COLOR = 1'b1
  } cfg_reg_t;

  localparam logic [1:0]  SCALE_RESET = 2'd2;
  localparam logic [15:0] COLOR_RESET = 16'd61343;

  // Glyph of a character code, top row in the most significant five bits and
  // bit 4 of each row being the leftmost column. Unknown codes are blank.
  function automatic logic [34:0] glyph(input logic [7:0] code_in);
    logic [7:0]  code;
    logic [34:0] g;
    code = code_in;
    if (code >= 8'h61 && code <= 8'h7a) begin
      code = code - 8'h20;
    end
    case (code)
      8'h30: g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      8'h31: g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      8'h32: g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      8'h33: g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      8'h34: g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      8'h35: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      8'h36: g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      8'h37: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      8'h38: g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      8'h39: g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      8'h41: g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h42: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      8'h43: g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      8'h44: g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      8'h45: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      8'h46: g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h47: g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      8'h48: g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      8'h49: g = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      8'h4a: g = {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
      8'h4b: g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      8'h4c: g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      8'h4d: g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      8'h4e: g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      8'h4f: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h50: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      8'h51: g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      8'h52: g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      8'h53: g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      8'h54: g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      8'h55: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      8'h56: g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      8'h57: g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      8'h58: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      8'h59: g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      8'h5a: g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      8'h2d: g = {5'd0,  5'd0,  5'd0,  5'd14, 5'd0,  5'd0,  5'd0};
      8'h5f: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31};
      8'h2e: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4};
      8'h3a: g = {5'd0,  5'd0,  5'd4,  5'd0,  5'd0,  5'd4,  5'd0};
      8'h2f: g = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16};
      8'h25: g = {5'd17, 5'd2,  5'd4,  5'd4,  5'd8,  5'd16, 5'd17};
      8'h2b: g = {5'd0,  5'd0,  5'd4,  5'd14, 5'd4,  5'd0,  5'd0};
      8'h2c: g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8};
      8'h3d: g = {5'd0,  5'd0,  5'd14, 5'd0,  5'd14, 5'd0,  5'd0};
      8'h23: g = {5'd0,  5'd10, 5'd31, 5'd10, 5'd31, 5'd10, 5'd0};
      8'h7c: g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      8'h24: g = {5'd4,  5'd15, 5'd20, 5'd14, 5'd5,  5'd30, 5'd4};
      8'h28: g = {5'd0,  5'd2,  5'd4,  5'd4,  5'd4,  5'd2,  5'd0};
      8'h29: g = {5'd0,  5'd8,  5'd4,  5'd4,  5'd4,  5'd8,  5'd0};
      default: g = 35'd0;
    endcase
    return g;
  endfunction

  // Small quotient of a value by the scale (1..3); scale 3 uses 11/32.
  function automatic logic [4:0] div_by_scale(input logic [4:0] v, input logic [1:0] s);
    logic [9:0] p;
    logic [4:0] q;
    p = 10'(v) * 10'd11;
    case (s)
      2'd2:    q = v >> 1;
      2'd3:    q = p[9:5];
      default: q = v;
    endcase
    return q;
  endfunction

endpackage

/* hdl/txtovl_if.sv */
// Handshake channels of the text band overlay: input items and result items.
interface txtovl_in_if import txtovl_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic        command;
  logic        restart;
  logic [7:0]  char_code;
  logic [15:0] background_pixel;

  modport source (output valid, command, restart, char_code, background_pixel,
                  input ready);
  modport sink   (input valid, command, restart, char_code, background_pixel,
                  output ready);
endinterface

interface txtovl_out_if import txtovl_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        text_hit;
  logic        band_end;

  modport source (output valid, pixel_out, text_hit, band_end, input ready);
  modport sink   (input valid, pixel_out, text_hit, band_end, output ready);
endinterface

/* hdl/scaled_5x7_text_band_overlay.sv */
// Top level of the scaled 5x7 text band overlay: line store, raster counters and pipeline.
//
//   channel   direction  beat
//   in_ch     sink       one append (command 0) or one background pixel (command 1)
//   out_ch    source     one composited pixel per background pixel beat
//   cfg_*     write      scale (index 0) and text colour (index 1)
//
// One beat is accepted per cycle unless a stalled result has filled all stages before it.
// The stages are: input register (cell quotient), line store read, glyph lookup.
// Appends write the line store in the read stage, so order with pixels is kept.
// Each stage moves on when the one after it is empty or moving, so the input keeps
// accepting while bubbles remain behind a stalled result.
// Reset is synchronous; the line store is not cleared and needs no sweep.
module scaled_5x7_text_band_overlay
  import txtovl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  txtovl_in_if.sink    in_ch,
  txtovl_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // Configuration and raster state.
  logic [1:0]         scale;
  logic [15:0]        text_color;
  logic [COUNT_W-1:0] char_count;
  logic [COL_W-1:0]   column_counter;
  logic [ROW_W-1:0]   row_counter;

  // Stage A: accepted beat.
  logic               a_valid;
  logic               a_pix;
  logic               a_wr_en;
  logic [ADDR_W-1:0]  a_wr_addr;
  logic [7:0]         a_code;
  logic [COL_W-1:0]   a_c;
  logic               a_col_ok;
  logic [ADDR_W-1:0]  a_q;
  logic [ROW_W-1:0]   a_row;
  logic [1:0]         a_scale;
  logic [COUNT_W-1:0] a_cc;
  logic [15:0]        a_bg;
  logic               a_end;

  // Stage B: line store data and glyph position.
  logic               b_valid;
  logic [7:0]         b_code;
  logic               b_draw;
  logic [2:0]         b_gcol;
  logic [ROW_W-1:0]   b_grow;
  logic [15:0]        b_bg;
  logic               b_end;

  // Output register.
  logic               o_valid;
  logic [15:0]        o_pixel;
  logic               o_hit;
  logic               o_end;

  logic [7:0] line_store [MAX_CHARS];

  // Stage moves.
  logic load_o_ok, load_b_ok, load_a_ok, acc, move_ab, move_bo;

  assign load_o_ok = !o_valid || out_ch.ready;
  assign load_b_ok = !b_valid || load_o_ok;
  assign load_a_ok = !a_valid || load_b_ok;
  assign acc       = in_ch.valid && load_a_ok;
  assign move_ab   = a_valid && load_b_ok;
  assign move_bo   = b_valid && load_o_ok;
  assign in_ch.ready = load_a_ok;

  // Raster step and cell quotient at acceptance.
  logic [COL_W-1:0] c_full;
  logic [9:0]       recip;
  logic [18:0]      c_prod;
  logic [2:0]       seff;
  logic [5:0]       height;
  logic             col_wrap, row_wrap;

  always_comb begin
    c_full = column_counter - COL_W'(TEXT_START_COL);
    case (scale)
      2'd2:    recip = RECIP_S2;
      2'd3:    recip = RECIP_S3;
      default: recip = RECIP_S1;
    endcase
    c_prod   = 19'(c_full) * 19'(recip);
    seff     = (scale == 2'd0) ? 3'd1 : {1'b0, scale};
    height   = 6'(GLYPH_ROWS) * 6'(seff);
    col_wrap = (11'(column_counter) + 11'd1) >= 11'(LINE_WIDTH);
    row_wrap = (6'(row_counter) + 6'd1) >= height;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= SCALE_RESET;
      text_color <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:      scale      <= cfg_data[1:0];
        REG_TEXT_COLOR: text_color <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Counters and input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      char_count     <= '0;
      column_counter <= '0;
      row_counter    <= '0;
    end else begin
      if (acc) begin
        a_valid <= 1'b1;
      end else if (move_ab) begin
        a_valid <= 1'b0;
      end
      if (acc && !in_ch.command) begin
        if (in_ch.restart) begin
          char_count <= COUNT_W'(1);
        end else if (char_count < COUNT_W'(MAX_CHARS)) begin
          char_count <= char_count + COUNT_W'(1);
        end
      end
      if (acc && in_ch.command) begin
        if (col_wrap) begin
          column_counter <= '0;
          row_counter    <= row_wrap ? '0 : row_counter + ROW_W'(1);
        end else begin
          column_counter <= column_counter + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pix     <= in_ch.command;
      a_wr_en   <= in_ch.restart || (char_count < COUNT_W'(MAX_CHARS));
      a_wr_addr <= in_ch.restart ? '0 : char_count[ADDR_W-1:0];
      a_code    <= in_ch.char_code;
      a_c       <= c_full;
      a_col_ok  <= column_counter >= COL_W'(TEXT_START_COL);
      a_q       <= c_prod[RECIP_SHIFT +: ADDR_W];
      a_row     <= row_counter;
      a_scale   <= scale;
      a_cc      <= char_count;
      a_bg      <= in_ch.background_pixel;
      a_end     <= col_wrap && row_wrap;
    end
  end

  // Offset inside the cell and drawing conditions.
  logic [4:0]  cell_span;
  logic [10:0] cell_start;
  logic [COL_W-1:0] off;
  logic [4:0]  glyph_w;
  logic [11:0] cell_end;
  logic        draw;

  always_comb begin
    cell_span  = 5'(CELL_COLS) * 5'(a_scale);
    glyph_w    = 5'(GLYPH_COLS) * 5'(a_scale);
    cell_start = 11'(cell_span) * 11'(a_q);
    off        = a_c - cell_start[COL_W-1:0];
    cell_end   = 12'(TEXT_START_COL) + 12'(cell_start) + 12'(glyph_w);
    draw = (a_scale != 2'd0)
        && ((5'(GLYPH_ROWS) * 5'(a_scale)) <= 5'(BAND_ROWS))
        && a_col_ok
        && (COUNT_W'(a_q) < a_cc)
        && (off < COL_W'(glyph_w))
        && (cell_end <= 12'(LINE_WIDTH));
  end

  // Line store: pixels read and appends write in the same stage.
  always_ff @(posedge clk) begin
    if (move_ab) begin
      if (a_pix) begin
        b_code <= line_store[a_q];
      end else if (a_wr_en) begin
        line_store[a_wr_addr] <= a_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load_b_ok) begin
      b_valid <= a_valid && a_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_draw <= draw;
      b_gcol <= 3'(div_by_scale(off[4:0], a_scale));
      b_grow <= ROW_W'(div_by_scale(5'(a_row), a_scale));
      b_bg   <= a_bg;
      b_end  <= a_end;
    end
  end

  // Glyph lookup and output register.
  logic [34:0] g_bits;
  logic [4:0]  row_bits;
  logic        hit;

  always_comb begin
    g_bits   = glyph(b_code);
    row_bits = 5'd0;
    if (b_grow < ROW_W'(GLYPH_ROWS)) begin
      row_bits = g_bits[6'(34) - 6'(b_grow[2:0]) * 6'd5 -: 5];
    end
    hit = b_draw && row_bits[3'd4 - b_gcol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_o_ok) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move_bo) begin
      o_pixel <= hit ? text_color : b_bg;
      o_hit   <= hit;
      o_end   <= b_end;
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.pixel_out = o_pixel;
  assign out_ch.text_hit  = o_hit;
  assign out_ch.band_end  = o_end;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    char_count <= COUNT_W'(MAX_CHARS))
    else $error("line store count beyond capacity");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_counter < COL_W'(LINE_WIDTH))
    else $error("column counter beyond line width");

  a_hit_color: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.text_hit) |-> (out_ch.pixel_out == text_color))
    else $error("text pixel not in text colour");

  a_end_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.command && col_wrap && row_wrap) |=>
      (column_counter == '0 && row_counter == '0))
    else $error("counters did not wrap at band end");

  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !load_o_ok) |=> b_valid)
    else $error("stalled pixel lost in read stage");
`endif

endmodule
